FILE: rtl/core/forb_pkg.sv
// forb_pkg: shared types, constants and rounding helpers of the frame builder
`timescale 1ns / 1ps

package forb_pkg;

    // field and internal widths
    localparam int IN_W   = 24;     // Q8.16 input components
    localparam int OUT_W  = 16;     // Q2.14 output components
    localparam int Q30_W  = 32;     // signed Q2.30 unit vector components
    localparam int MAG_W  = 30;     // scaled magnitude before the square root
    localparam int ROOT_W = 31;     // square root and quotient width
    localparam int ACC_W  = 66;     // dot products and cross products
    localparam int NUDGE_W = 34;    // unit vector plus nudge
    localparam int ORTHO_W = 64;    // orthogonalized reference, Q4.60

    // 0.99 of one in Q4.60
    localparam logic signed [ACC_W-1:0] NEAR_T = ACC_W'((ACC_W'(1) << 60) / 100 * 99);

    // nudge amounts in Q4.30
    localparam logic signed [NUDGE_W-1:0] NUDGE_5 = NUDGE_W'(5) << 30;
    localparam logic signed [NUDGE_W-1:0] NUDGE_2 = NUDGE_W'(2) << 30;
    localparam logic [Q30_W-1:0]          UNIT_ONE = Q30_W'(1) << 30;

    localparam logic signed [ACC_W-1:0] Q14_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] Q14_MIN = -ACC_W'(32768);

    typedef logic [2:0][Q30_W-1:0] vec_t;

    typedef struct packed {
        logic signed [IN_W-1:0] dir_x;
        logic signed [IN_W-1:0] dir_y;
        logic signed [IN_W-1:0] dir_z;
        logic signed [IN_W-1:0] ref_x;
        logic signed [IN_W-1:0] ref_y;
        logic signed [IN_W-1:0] ref_z;
        logic                   ref_given;
    } in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] right_x;
        logic signed [OUT_W-1:0] right_y;
        logic signed [OUT_W-1:0] right_z;
        logic signed [OUT_W-1:0] up_out_x;
        logic signed [OUT_W-1:0] up_out_y;
        logic signed [OUT_W-1:0] up_out_z;
        logic signed [OUT_W-1:0] fwd_x;
        logic signed [OUT_W-1:0] fwd_y;
        logic signed [OUT_W-1:0] fwd_z;
        logic                    degenerate;
    } out_t;

    // dot product beyond 0.99 either way
    function automatic logic near_par(input logic signed [ACC_W-1:0] d);
        return (d > NEAR_T) || (d < -NEAR_T);
    endfunction

    // round half away from zero by sh bits
    function automatic logic signed [ACC_W-1:0] rnd_sh(input logic signed [ACC_W-1:0] v,
                                                     input int sh);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] r;
        mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        r   = (mag + (ACC_W'(1) << (sh - 1))) >> sh;
        return v[ACC_W-1] ? $signed(-r) : $signed(r);
    endfunction

    // round to Q2.14 and saturate
    function automatic logic [OUT_W-1:0] to_q14(input logic signed [ACC_W-1:0] v,
                                                 input int sh);
        logic signed [ACC_W-1:0] r;
        logic [OUT_W-1:0]        q;
        r = rnd_sh(v, sh);
        if (r > Q14_MAX) begin
            q = OUT_W'(32767);
        end else if (r < Q14_MIN) begin
            q = OUT_W'(32768);
        end else begin
            q = r[OUT_W-1:0];
        end
        return q;
    endfunction

endpackage

FILE: rtl/core/frame_of_reference_builder.sv
// frame_of_reference_builder: orthonormal right/up/forward frame from a direction
// pipeline: four normalizers in series, each a 31-stage square root and a 31-stage
//   divider, plus dot, Gram-Schmidt and cross product stages
// throughput: one request per cycle; a stalled result holds the whole pipeline
// reset: aresetn clears every stage valid bit, payload registers are not reset
`timescale 1ns / 1ps

module frame_of_reference_builder (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  forb_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output forb_pkg::out_t  m_data
);
    localparam int IW  = forb_pkg::IN_W;
    localparam int QW  = forb_pkg::Q30_W;
    localparam int AW  = forb_pkg::ACC_W;
    localparam int TW  = forb_pkg::NUDGE_W;
    localparam int OW  = forb_pkg::ORTHO_W;
    localparam int DQW = QW + 1;

    typedef struct packed {
        forb_pkg::vec_t f;
        forb_pkg::vec_t p;
        logic           near;
        logic           degen;
    } nudge_side_t;

    typedef struct packed {
        forb_pkg::vec_t f;
        logic           degen;
    } ortho_side_t;

    typedef logic [2:0][2*QW-1:0] prod_t;

    logic m_valid_reg;
    logic adv;

    // whole pipeline moves unless a finished result is waiting
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // forward and reference normalizers
    logic [2:0][IW-1:0] dir_vec;
    logic [2:0][IW-1:0] ref_vec;
    logic               nd_valid;
    forb_pkg::vec_t     nd_vec;
    logic               nd_nz;
    logic               nd_given;
    forb_pkg::vec_t     nr_vec;
    logic               nr_nz;

    assign dir_vec = {s_data.dir_z, s_data.dir_y, s_data.dir_x};
    assign ref_vec = {s_data.ref_z, s_data.ref_y, s_data.ref_x};

    forb_norm #(.W(IW), .PW(1)) u_norm_dir (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid && s_ready),
        .in_vec    (dir_vec),
        .in_side   (s_data.ref_given),
        .out_valid (nd_valid),
        .out_vec   (nd_vec),
        .out_nz    (nd_nz),
        .out_side  (nd_given)
    );

    forb_norm #(.W(IW), .PW(1)) u_norm_ref (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid && s_ready),
        .in_vec    (ref_vec),
        .in_side   (s_data.ref_given),
        .out_valid (),
        .out_vec   (nr_vec),
        .out_nz    (nr_nz),
        .out_side  ()
    );

    // g: pick reference, then first parallel test
    logic           g1_valid_reg, g2_valid_reg, g3_valid_reg;
    forb_pkg::vec_t g1_f_reg, g2_f_reg, g3_f_reg;
    forb_pkg::vec_t g1_p_reg, g2_p_reg, g3_p_reg;
    logic           g1_degen_reg, g2_degen_reg, g3_degen_reg;
    prod_t          g2_prod_reg;
    logic [AW-1:0]  g3_dot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g1_valid_reg <= 1'b0;
            g2_valid_reg <= 1'b0;
            g3_valid_reg <= 1'b0;
        end else if (adv) begin
            g1_valid_reg <= nd_valid;
            g2_valid_reg <= g1_valid_reg;
            g3_valid_reg <= g2_valid_reg;
        end
        if (adv) begin
            g1_f_reg     <= nd_vec;
            g1_p_reg     <= nd_given ? nr_vec : {QW'(0), forb_pkg::UNIT_ONE, QW'(0)};
            g1_degen_reg <= !nd_nz || (nd_given && !nr_nz);
            for (int c = 0; c < 3; c++) begin
                g2_prod_reg[c] <= $signed(g1_f_reg[c]) * $signed(g1_p_reg[c]);
            end
            g2_f_reg     <= g1_f_reg;
            g2_p_reg     <= g1_p_reg;
            g2_degen_reg <= g1_degen_reg;
            g3_dot_reg   <= AW'($signed(g2_prod_reg[0])) + AW'($signed(g2_prod_reg[1]))
                          + AW'($signed(g2_prod_reg[2]));
            g3_f_reg     <= g2_f_reg;
            g3_p_reg     <= g2_p_reg;
            g3_degen_reg <= g2_degen_reg;
        end
    end

    // first nudge by (+5,+5,+5)
    logic [2:0][TW-1:0] t1_vec;
    nudge_side_t        n1_in_side;
    nudge_side_t        n1_out_side;
    logic               n1_valid;
    forb_pkg::vec_t     n1_vec;
    logic               n1_nz;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            t1_vec[c] = TW'($signed(g3_p_reg[c])) + forb_pkg::NUDGE_5;
        end
        n1_in_side.f     = g3_f_reg;
        n1_in_side.p     = g3_p_reg;
        n1_in_side.near  = forb_pkg::near_par($signed(g3_dot_reg));
        n1_in_side.degen = g3_degen_reg;
    end

    forb_norm #(.W(TW), .PW($bits(nudge_side_t))) u_norm_nudge1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (g3_valid_reg),
        .in_vec    (t1_vec),
        .in_side   (n1_in_side),
        .out_valid (n1_valid),
        .out_vec   (n1_vec),
        .out_nz    (n1_nz),
        .out_side  (n1_out_side)
    );

    // h: take the nudged reference if needed, second parallel test
    logic           h1_valid_reg, h2_valid_reg, h3_valid_reg;
    forb_pkg::vec_t h1_f_reg, h2_f_reg, h3_f_reg;
    forb_pkg::vec_t h1_p_reg, h2_p_reg, h3_p_reg;
    logic           h1_near_reg, h2_near_reg, h3_near_reg;
    logic           h1_degen_reg, h2_degen_reg, h3_degen_reg;
    prod_t          h2_prod_reg;
    logic [AW-1:0]  h3_dot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h1_valid_reg <= 1'b0;
            h2_valid_reg <= 1'b0;
            h3_valid_reg <= 1'b0;
        end else if (adv) begin
            h1_valid_reg <= n1_valid;
            h2_valid_reg <= h1_valid_reg;
            h3_valid_reg <= h2_valid_reg;
        end
        if (adv) begin
            h1_f_reg     <= n1_out_side.f;
            h1_p_reg     <= (n1_out_side.near && n1_nz) ? n1_vec : n1_out_side.p;
            h1_near_reg  <= n1_out_side.near;
            h1_degen_reg <= n1_out_side.degen;
            for (int c = 0; c < 3; c++) begin
                h2_prod_reg[c] <= $signed(h1_f_reg[c]) * $signed(h1_p_reg[c]);
            end
            h2_f_reg     <= h1_f_reg;
            h2_p_reg     <= h1_p_reg;
            h2_near_reg  <= h1_near_reg;
            h2_degen_reg <= h1_degen_reg;
            h3_dot_reg   <= AW'($signed(h2_prod_reg[0])) + AW'($signed(h2_prod_reg[1]))
                          + AW'($signed(h2_prod_reg[2]));
            h3_f_reg     <= h2_f_reg;
            h3_p_reg     <= h2_p_reg;
            h3_near_reg  <= h2_near_reg;
            h3_degen_reg <= h2_degen_reg;
        end
    end

    // second nudge by (+5,-2,-5)
    logic [2:0][TW-1:0] t2_vec;
    nudge_side_t        n2_in_side;
    nudge_side_t        n2_out_side;
    logic               n2_valid;
    forb_pkg::vec_t     n2_vec;
    logic               n2_nz;

    always_comb begin
        t2_vec[0] = TW'($signed(h3_p_reg[0])) + forb_pkg::NUDGE_5;
        t2_vec[1] = TW'($signed(h3_p_reg[1])) - forb_pkg::NUDGE_2;
        t2_vec[2] = TW'($signed(h3_p_reg[2])) - forb_pkg::NUDGE_5;
        n2_in_side.f     = h3_f_reg;
        n2_in_side.p     = h3_p_reg;
        n2_in_side.near  = h3_near_reg && forb_pkg::near_par($signed(h3_dot_reg));
        n2_in_side.degen = h3_degen_reg;
    end

    forb_norm #(.W(TW), .PW($bits(nudge_side_t))) u_norm_nudge2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (h3_valid_reg),
        .in_vec    (t2_vec),
        .in_side   (n2_in_side),
        .out_valid (n2_valid),
        .out_vec   (n2_vec),
        .out_nz    (n2_nz),
        .out_side  (n2_out_side)
    );

    // j: Gram-Schmidt, r = p*2^30 - f*round(f.p)
    logic                    j1_valid_reg, j2_valid_reg, j3_valid_reg;
    logic                    j4_valid_reg, j5_valid_reg, j6_valid_reg;
    forb_pkg::vec_t          j1_f_reg, j2_f_reg, j3_f_reg, j4_f_reg, j5_f_reg, j6_f_reg;
    forb_pkg::vec_t          j1_p_reg, j2_p_reg, j3_p_reg, j4_p_reg, j5_p_reg;
    logic                    j1_degen_reg, j2_degen_reg, j3_degen_reg;
    logic                    j4_degen_reg, j5_degen_reg, j6_degen_reg;
    prod_t                   j2_prod_reg;
    logic [AW-1:0]           j3_dot_reg;
    logic [DQW-1:0]          j4_dq_reg;
    logic [2:0][2*QW:0]      j5_fdq_reg;
    logic [2:0][OW-1:0]      j6_t_reg;
    logic [AW-1:0]           dq_full;

    assign dq_full = forb_pkg::rnd_sh($signed(j3_dot_reg), 30);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            j1_valid_reg <= 1'b0;
            j2_valid_reg <= 1'b0;
            j3_valid_reg <= 1'b0;
            j4_valid_reg <= 1'b0;
            j5_valid_reg <= 1'b0;
            j6_valid_reg <= 1'b0;
        end else if (adv) begin
            j1_valid_reg <= n2_valid;
            j2_valid_reg <= j1_valid_reg;
            j3_valid_reg <= j2_valid_reg;
            j4_valid_reg <= j3_valid_reg;
            j5_valid_reg <= j4_valid_reg;
            j6_valid_reg <= j5_valid_reg;
        end
        if (adv) begin
            j1_f_reg     <= n2_out_side.f;
            j1_p_reg     <= (n2_out_side.near && n2_nz) ? n2_vec : n2_out_side.p;
            j1_degen_reg <= n2_out_side.degen;
            for (int c = 0; c < 3; c++) begin
                j2_prod_reg[c] <= $signed(j1_f_reg[c]) * $signed(j1_p_reg[c]);
            end
            j2_f_reg     <= j1_f_reg;
            j2_p_reg     <= j1_p_reg;
            j2_degen_reg <= j1_degen_reg;
            j3_dot_reg   <= AW'($signed(j2_prod_reg[0])) + AW'($signed(j2_prod_reg[1]))
                          + AW'($signed(j2_prod_reg[2]));
            j3_f_reg     <= j2_f_reg;
            j3_p_reg     <= j2_p_reg;
            j3_degen_reg <= j2_degen_reg;
            j4_dq_reg    <= dq_full[DQW-1:0];
            j4_f_reg     <= j3_f_reg;
            j4_p_reg     <= j3_p_reg;
            j4_degen_reg <= j3_degen_reg;
            for (int c = 0; c < 3; c++) begin
                j5_fdq_reg[c] <= $signed(j4_f_reg[c]) * $signed(j4_dq_reg);
            end
            j5_f_reg     <= j4_f_reg;
            j5_p_reg     <= j4_p_reg;
            j5_degen_reg <= j4_degen_reg;
            for (int c = 0; c < 3; c++) begin
                j6_t_reg[c] <= OW'($signed({j5_p_reg[c], 30'b0}) - $signed(j5_fdq_reg[c]));
            end
            j6_f_reg     <= j5_f_reg;
            j6_degen_reg <= j5_degen_reg;
        end
    end

    // up normalizer
    ortho_side_t    n3_in_side;
    ortho_side_t    n3_out_side;
    logic           n3_valid;
    forb_pkg::vec_t n3_vec;
    logic           n3_nz;

    assign n3_in_side.f     = j6_f_reg;
    assign n3_in_side.degen = j6_degen_reg;

    forb_norm #(.W(OW), .PW($bits(ortho_side_t))) u_norm_up (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (j6_valid_reg),
        .in_vec    (j6_t_reg),
        .in_side   (n3_in_side),
        .out_valid (n3_valid),
        .out_vec   (n3_vec),
        .out_nz    (n3_nz),
        .out_side  (n3_out_side)
    );

    // k: cross product f x u
    logic                 k1_valid_reg, k2_valid_reg;
    forb_pkg::vec_t       k1_f_reg, k2_f_reg;
    forb_pkg::vec_t       k1_u_reg, k2_u_reg;
    logic                 k1_nz_reg, k2_nz_reg;
    logic                 k1_degen_reg, k2_degen_reg;
    logic [5:0][2*QW-1:0] k1_prod_reg;
    logic [2:0][AW-1:0]   k2_c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k1_valid_reg <= 1'b0;
            k2_valid_reg <= 1'b0;
        end else if (adv) begin
            k1_valid_reg <= n3_valid;
            k2_valid_reg <= k1_valid_reg;
        end
        if (adv) begin
            k1_prod_reg[0] <= $signed(n3_out_side.f[1]) * $signed(n3_vec[2]);
            k1_prod_reg[1] <= $signed(n3_out_side.f[2]) * $signed(n3_vec[1]);
            k1_prod_reg[2] <= $signed(n3_out_side.f[2]) * $signed(n3_vec[0]);
            k1_prod_reg[3] <= $signed(n3_out_side.f[0]) * $signed(n3_vec[2]);
            k1_prod_reg[4] <= $signed(n3_out_side.f[0]) * $signed(n3_vec[1]);
            k1_prod_reg[5] <= $signed(n3_out_side.f[1]) * $signed(n3_vec[0]);
            k1_f_reg       <= n3_out_side.f;
            k1_u_reg       <= n3_vec;
            k1_nz_reg      <= n3_nz;
            k1_degen_reg   <= n3_out_side.degen;
            for (int c = 0; c < 3; c++) begin
                k2_c_reg[c] <= AW'($signed(k1_prod_reg[2*c]))
                             - AW'($signed(k1_prod_reg[2*c+1]));
            end
            k2_f_reg     <= k1_f_reg;
            k2_u_reg     <= k1_u_reg;
            k2_nz_reg    <= k1_nz_reg;
            k2_degen_reg <= k1_degen_reg;
        end
    end

    // output register: round to Q2.14, zero on degenerate, up and right also zero for a zero up vector
    forb_pkg::out_t m_data_reg;
    forb_pkg::out_t m_data_next;
    logic           keep_up;

    assign keep_up = k2_nz_reg && !k2_degen_reg;

    always_comb begin
        m_data_next            = '0;
        m_data_next.degenerate = k2_degen_reg;
        if (!k2_degen_reg) begin
            m_data_next.fwd_x = forb_pkg::to_q14(AW'($signed(k2_f_reg[0])), 16);
            m_data_next.fwd_y = forb_pkg::to_q14(AW'($signed(k2_f_reg[1])), 16);
            m_data_next.fwd_z = forb_pkg::to_q14(AW'($signed(k2_f_reg[2])), 16);
        end
        if (keep_up) begin
            m_data_next.up_out_x = forb_pkg::to_q14(AW'($signed(k2_u_reg[0])), 16);
            m_data_next.up_out_y = forb_pkg::to_q14(AW'($signed(k2_u_reg[1])), 16);
            m_data_next.up_out_z = forb_pkg::to_q14(AW'($signed(k2_u_reg[2])), 16);
            m_data_next.right_x  = forb_pkg::to_q14($signed(k2_c_reg[0]), 46);
            m_data_next.right_y  = forb_pkg::to_q14($signed(k2_c_reg[1]), 46);
            m_data_next.right_z  = forb_pkg::to_q14($signed(k2_c_reg[2]), 46);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= k2_valid_reg;
        end
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // degenerate results carry all-zero vectors
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |->
            m_data.fwd_x == 0 && m_data.fwd_y == 0 && m_data.fwd_z == 0 &&
            m_data.up_out_x == 0 && m_data.up_out_y == 0 && m_data.up_out_z == 0 &&
            m_data.right_x == 0 && m_data.right_y == 0 && m_data.right_z == 0)
        else $error("degenerate result with nonzero vector");

    // forward is a unit vector, no component beyond one
    a_fwd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            m_data.fwd_x <= 16384 && m_data.fwd_x >= -16384 &&
            m_data.fwd_y <= 16384 && m_data.fwd_y >= -16384 &&
            m_data.fwd_z <= 16384 && m_data.fwd_z >= -16384)
        else $error("forward component out of unit range");

    // up is a unit vector, no component beyond one
    a_up_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            m_data.up_out_x <= 16384 && m_data.up_out_x >= -16384 &&
            m_data.up_out_y <= 16384 && m_data.up_out_y >= -16384 &&
            m_data.up_out_z <= 16384 && m_data.up_out_z >= -16384)
        else $error("up component out of unit range");

endmodule

FILE: rtl/core/forb_norm.sv
// forb_norm: pipelined vector normalizer to Q2.30 (scale, square root, divide)
`timescale 1ns / 1ps

module forb_norm #(
    parameter int W  = forb_pkg::IN_W,
    parameter int PW = 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic [2:0][W-1:0]     in_vec,
    input  logic [PW-1:0]         in_side,
    output logic                  out_valid,
    output forb_pkg::vec_t        out_vec,
    output logic                  out_nz,
    output logic [PW-1:0]         out_side
);
    localparam int MW  = forb_pkg::MAG_W;
    localparam int SW  = forb_pkg::ROOT_W;
    localparam int LW  = 2 * SW;
    localparam int XW  = W + MW;
    localparam int NW  = SW + MW;
    localparam int PSW = $clog2(W) + 1;
    localparam int QW  = forb_pkg::Q30_W;

    // stage a: magnitudes and signs
    logic                 a_valid_reg;
    logic [2:0][W-1:0]    a_mag_reg;
    logic [2:0][W-1:0]    a_mag_next;
    logic [2:0]           a_neg_reg;
    logic [PW-1:0]        a_side_reg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            a_mag_next[c] = in_vec[c][W-1] ? (~in_vec[c] + W'(1)) : in_vec[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= in_valid;
        end
        if (adv) begin
            a_mag_reg <= a_mag_next;
            for (int c = 0; c < 3; c++) begin
                a_neg_reg[c] <= in_vec[c][W-1];
            end
            a_side_reg <= in_side;
        end
    end

    // stage b: leading one of the largest magnitude
    logic                 b_valid_reg;
    logic [2:0][W-1:0]    b_mag_reg;
    logic [2:0]           b_neg_reg;
    logic                 b_nz_reg;
    logic [PSW-1:0]       b_pos_reg;
    logic [PSW-1:0]       b_pos_next;
    logic [PW-1:0]        b_side_reg;
    logic [W-1:0]         mag_or;

    assign mag_or = a_mag_reg[0] | a_mag_reg[1] | a_mag_reg[2];

    always_comb begin
        b_pos_next = '0;
        for (int i = 0; i < W; i++) begin
            if (mag_or[i]) begin
                b_pos_next = PSW'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= a_valid_reg;
        end
        if (adv) begin
            b_mag_reg  <= a_mag_reg;
            b_neg_reg  <= a_neg_reg;
            b_nz_reg   <= |mag_or;
            b_pos_reg  <= b_pos_next;
            b_side_reg <= a_side_reg;
        end
    end

    // stage c: common shift so the largest lands in [2^29, 2^30)
    logic                 c_valid_reg;
    logic [2:0][MW-1:0]   c_m_reg;
    logic [2:0][MW-1:0]   c_m_next;
    logic [2:0]           c_neg_reg;
    logic                 c_nz_reg;
    logic [PW-1:0]        c_side_reg;
    logic [2:0][XW-1:0]   c_wide;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (b_pos_reg >= PSW'(MW - 1)) begin
                c_wide[c] = XW'(b_mag_reg[c]) >> (b_pos_reg - PSW'(MW - 1));
            end else begin
                c_wide[c] = XW'(b_mag_reg[c]) << (PSW'(MW - 1) - b_pos_reg);
            end
            c_m_next[c] = c_wide[c][MW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            c_valid_reg <= b_valid_reg;
        end
        if (adv) begin
            c_m_reg    <= c_m_next;
            c_neg_reg  <= b_neg_reg;
            c_nz_reg   <= b_nz_reg;
            c_side_reg <= b_side_reg;
        end
    end

    // stage d: squares
    logic                   d_valid_reg;
    logic [2:0][2*MW-1:0]   d_sq_reg;
    logic [2:0][MW-1:0]     d_m_reg;
    logic [2:0]             d_neg_reg;
    logic                   d_nz_reg;
    logic [PW-1:0]          d_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (adv) begin
            d_valid_reg <= c_valid_reg;
        end
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                d_sq_reg[c] <= c_m_reg[c] * c_m_reg[c];
            end
            d_m_reg    <= c_m_reg;
            d_neg_reg  <= c_neg_reg;
            d_nz_reg   <= c_nz_reg;
            d_side_reg <= c_side_reg;
        end
    end

    // square root: one result bit per stage, stage 0 holds the sum of squares
    logic                 sq_valid_reg [0:SW];
    logic [LW-1:0]        sq_l_reg     [0:SW];
    logic [SW-1:0]        sq_root_reg  [0:SW];
    logic [SW:0]          sq_rem_reg   [0:SW];
    logic [2:0][MW-1:0]   sq_m_reg     [0:SW];
    logic [2:0]           sq_neg_reg   [0:SW];
    logic                 sq_nz_reg    [0:SW];
    logic [PW-1:0]        sq_side_reg  [0:SW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            sq_valid_reg[0] <= d_valid_reg;
        end
        if (adv) begin
            sq_l_reg[0]    <= LW'(d_sq_reg[0]) + LW'(d_sq_reg[1]) + LW'(d_sq_reg[2]);
            sq_root_reg[0] <= '0;
            sq_rem_reg[0]  <= '0;
            sq_m_reg[0]    <= d_m_reg;
            sq_neg_reg[0]  <= d_neg_reg;
            sq_nz_reg[0]   <= d_nz_reg;
            sq_side_reg[0] <= d_side_reg;
        end
    end

    for (genvar k = 0; k < SW; k++) begin : g_sqrt
        logic [SW+2:0] rem_sh;
        logic [SW+2:0] trial;
        logic          take;

        assign rem_sh = {sq_rem_reg[k], sq_l_reg[k][LW-1-2*k -: 2]};
        assign trial  = {1'b0, sq_root_reg[k], 2'b01};
        assign take   = rem_sh >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_valid_reg[k+1] <= 1'b0;
            end else if (adv) begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
            if (adv) begin
                sq_l_reg[k+1]    <= sq_l_reg[k];
                sq_root_reg[k+1] <= {sq_root_reg[k][SW-2:0], take};
                sq_rem_reg[k+1]  <= take ? (SW+1)'(rem_sh - trial) : rem_sh[SW:0];
                sq_m_reg[k+1]    <= sq_m_reg[k];
                sq_neg_reg[k+1]  <= sq_neg_reg[k];
                sq_nz_reg[k+1]   <= sq_nz_reg[k];
                sq_side_reg[k+1] <= sq_side_reg[k];
            end
        end
    end

    // divider: stage 0 forms (m << 30) + s/2, then one quotient bit per stage
    logic                 dv_valid_reg [0:SW];
    logic [2:0][SW-1:0]   dv_rem_reg   [0:SW];
    logic [2:0][SW-1:0]   dv_acc_reg   [0:SW];
    logic [SW-1:0]        dv_s_reg     [0:SW];
    logic [2:0]           dv_neg_reg   [0:SW];
    logic                 dv_nz_reg    [0:SW];
    logic [PW-1:0]        dv_side_reg  [0:SW];
    logic [2:0][NW-1:0]   dv_n;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            dv_n[c] = NW'({sq_m_reg[SW][c], MW'(0)}) + NW'(sq_root_reg[SW] >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_valid_reg[0] <= sq_valid_reg[SW];
        end
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                dv_rem_reg[0][c] <= SW'(dv_n[c][NW-1:SW]);
                dv_acc_reg[0][c] <= dv_n[c][SW-1:0];
            end
            dv_s_reg[0]    <= sq_root_reg[SW];
            dv_neg_reg[0]  <= sq_neg_reg[SW];
            dv_nz_reg[0]   <= sq_nz_reg[SW];
            dv_side_reg[0] <= sq_side_reg[SW];
        end
    end

    for (genvar j = 0; j < SW; j++) begin : g_div
        logic [2:0][SW:0] r2;
        logic [2:0]       ge;

        always_comb begin
            for (int c = 0; c < 3; c++) begin
                r2[c] = {dv_rem_reg[j][c], dv_acc_reg[j][c][SW-1]};
                ge[c] = r2[c] >= {1'b0, dv_s_reg[j]};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[j+1] <= 1'b0;
            end else if (adv) begin
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            end
            if (adv) begin
                for (int c = 0; c < 3; c++) begin
                    dv_rem_reg[j+1][c] <= ge[c] ? SW'(r2[c] - {1'b0, dv_s_reg[j]})
                                                : r2[c][SW-1:0];
                    dv_acc_reg[j+1][c] <= {dv_acc_reg[j][c][SW-2:0], ge[c]};
                end
                dv_s_reg[j+1]    <= dv_s_reg[j];
                dv_neg_reg[j+1]  <= dv_neg_reg[j];
                dv_nz_reg[j+1]   <= dv_nz_reg[j];
                dv_side_reg[j+1] <= dv_side_reg[j];
            end
        end
    end

    // output: restore signs, zero vector gives zeros
    logic                 out_valid_reg;
    forb_pkg::vec_t       out_vec_reg;
    forb_pkg::vec_t       out_vec_next;
    logic                 out_nz_reg;
    logic [PW-1:0]        out_side_reg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (!dv_nz_reg[SW]) begin
                out_vec_next[c] = '0;
            end else if (dv_neg_reg[SW][c]) begin
                out_vec_next[c] = QW'(-{1'b0, dv_acc_reg[SW][c]});
            end else begin
                out_vec_next[c] = QW'({1'b0, dv_acc_reg[SW][c]});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= dv_valid_reg[SW];
        end
        if (adv) begin
            out_vec_reg  <= out_vec_next;
            out_nz_reg   <= dv_nz_reg[SW];
            out_side_reg <= dv_side_reg[SW];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_vec   = out_vec_reg;
    assign out_nz    = out_nz_reg;
    assign out_side  = out_side_reg;

endmodule
